### rtl/core/pesr_pkg.sv
package pesr_pkg;

    // Field and datapath widths
    localparam int COORD_W  = 32;
    localparam int NAXES    = 3;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int SPACE_W  = 31;
    localparam int SQSUM_W  = 2 * DELTA_W;
    localparam int ROOT_W   = 34;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SUM_W    = ROOT_W + 1;
    localparam int PROD_W   = DELTA_W + SPACE_W;
    localparam int NUM_W    = PROD_W + 1;
    localparam int QUO_W    = DELTA_W;
    localparam int SQ_CNT_W = $clog2(ROOT_W + 1);
    localparam int DV_CNT_W = $clog2(QUO_W + 1);

    // Per-vertex point limit and its counter width
    localparam int MAX_PER_VERTEX = 64;
    localparam int NPT_W          = $clog2(MAX_PER_VERTEX + 1);

    localparam logic [SPACE_W-1:0] SPACE_RST = SPACE_W'(256);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SQR,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_SUM,
        ST_DECIDE,
        ST_MULQ,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PLACE
    } state_t;

    typedef enum logic {
        OUT_PEND,
        OUT_POINT
    } out_src_t;

    typedef struct packed {
        logic       load_vtx;
        logic       load_start;
        logic       delta;
        logic       sq_acc;
        logic       sq_first;
        logic [1:0] sq_sel;
        logic       sqrt_start;
        logic       sum;
        logic       dec_end;
        logic       dec_ovf;
        logic       mulq;
        logic       div_start;
        logic       place_loop;
        logic       place_end;
        logic       out_load;
        out_src_t   out_src;
        logic       out_last;
        logic       out_ovf;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic pend_valid;
        logic s_le_sp;
        logic s_le_2sp;
        logic d_zero;
        logic sqrt_done;
        logic div_done;
    } status_t;

endpackage

### rtl/core/pesr_sqrt.sv
module pesr_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pesr_pkg::SQSUM_W-1:0]  rad,
    output logic [pesr_pkg::ROOT_W-1:0]   root,
    output logic                          done
);

    logic [pesr_pkg::RAD_W-1:0]    rad_reg;
    logic [pesr_pkg::REM_W-1:0]    rem_reg;
    logic [pesr_pkg::ROOT_W-1:0]   root_reg;
    logic [pesr_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                          done_reg;

    logic [pesr_pkg::REM_W+1:0] rem_sh;
    logic [pesr_pkg::REM_W+1:0] trial;
    logic [pesr_pkg::REM_W+1:0] diff;
    logic                       ge;

    // One result bit per cycle: bring down two radicand bits, try root*4+1.
    always_comb begin
        rem_sh = {rem_reg, rad_reg[pesr_pkg::RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= pesr_pkg::SQ_CNT_W'(pesr_pkg::ROOT_W);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == pesr_pkg::SQ_CNT_W'(1));
            end
        end
    end

    // Working registers of the iteration
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= {{(pesr_pkg::RAD_W - pesr_pkg::SQSUM_W){1'b0}}, rad};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[pesr_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[pesr_pkg::REM_W-1:0] : rem_sh[pesr_pkg::REM_W-1:0];
            root_reg <= {root_reg[pesr_pkg::ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### rtl/core/pesr_div.sv
module pesr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pesr_pkg::NUM_W-1:0]  num,
    input  logic [pesr_pkg::ROOT_W-1:0] den,
    output logic [pesr_pkg::QUO_W-1:0]  quo,
    output logic                        done
);

    logic [pesr_pkg::ROOT_W-1:0]   rem_reg;
    logic [pesr_pkg::QUO_W-1:0]    sh_reg;
    logic [pesr_pkg::DV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;

    logic [pesr_pkg::ROOT_W:0] rem_sh;
    logic [pesr_pkg::ROOT_W:0] diff;
    logic                      ge;

    // Restoring division, one quotient bit per cycle. The quotient is known
    // to fit in QUO_W bits, so the upper numerator bits start as remainder.
    always_comb begin
        rem_sh = {rem_reg, sh_reg[pesr_pkg::QUO_W-1]};
        diff   = rem_sh - {1'b0, den};
        ge     = (rem_sh >= {1'b0, den});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= pesr_pkg::DV_CNT_W'(pesr_pkg::QUO_W);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == pesr_pkg::DV_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= pesr_pkg::ROOT_W'(num[pesr_pkg::NUM_W-1:pesr_pkg::QUO_W]);
            sh_reg  <= num[pesr_pkg::QUO_W-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[pesr_pkg::ROOT_W-1:0] : rem_sh[pesr_pkg::ROOT_W-1:0];
            sh_reg  <= {sh_reg[pesr_pkg::QUO_W-2:0], ge};
        end
    end

    assign quo  = sh_reg;
    assign done = done_reg;

endmodule

### rtl/core/pesr_dp.sv
module pesr_dp (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          cfg_we,
    input  logic [pesr_pkg::SPACE_W-1:0]                  cfg_data,
    input  logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] vtx_in,
    input  pesr_pkg::cmd_t                                cmd,
    output pesr_pkg::status_t                             status,
    input  logic                                          m_tready,
    output logic                                          m_tvalid,
    output logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] pt_out,
    output logic                                          last_out,
    output logic                                          ovf_out
);

    logic [pesr_pkg::SPACE_W-1:0]  spacing_reg;
    logic [pesr_pkg::SPACE_W-1:0]  sp;
    logic [pesr_pkg::SPACE_W-1:0]  left_reg;

    logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] cur_reg;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] vtx_reg;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] pend_reg;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] out_reg;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] point;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::DELTA_W-1:0] mag_reg;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::DELTA_W-1:0] mag_next;
    logic [pesr_pkg::NAXES-1:0]                        neg_reg;
    logic [pesr_pkg::NAXES-1:0]                        neg_next;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::PROD_W-1:0]  prod_reg;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::QUO_W-1:0]   quo;
    logic [pesr_pkg::NAXES-1:0]                        div_done;

    logic [pesr_pkg::SQSUM_W-1:0] sumsq_reg;
    logic [pesr_pkg::SQSUM_W-1:0] sq;
    logic [pesr_pkg::ROOT_W-1:0]  d;
    logic                         sqrt_done;
    logic [pesr_pkg::SUM_W-1:0]   s_reg;
    logic [pesr_pkg::SPACE_W-1:0] need_reg;
    logic                         d_zero_reg;
    logic                         pend_valid_reg;
    logic                         out_valid_reg;
    logic                         last_reg;
    logic                         ovf_reg;

    // A spacing of zero behaves as one.
    assign sp = (spacing_reg == '0) ? pesr_pkg::SPACE_W'(1) : spacing_reg;

    // Per-axis signed difference, split into sign and magnitude.
    always_comb begin
        for (int i = 0; i < pesr_pkg::NAXES; i++) begin
            logic [pesr_pkg::DELTA_W-1:0] df;
            df          = {vtx_reg[i][pesr_pkg::COORD_W-1], vtx_reg[i]}
                        - {cur_reg[i][pesr_pkg::COORD_W-1], cur_reg[i]};
            neg_next[i] = df[pesr_pkg::DELTA_W-1];
            mag_next[i] = df[pesr_pkg::DELTA_W-1] ? (~df + 1'b1) : df;
        end
    end

    // One shared squarer, one axis per cycle.
    assign sq = mag_reg[cmd.sq_sel] * mag_reg[cmd.sq_sel];

    // Interpolated point: current position moved by the rounded offset.
    always_comb begin
        for (int i = 0; i < pesr_pkg::NAXES; i++) begin
            logic [pesr_pkg::COORD_W+1:0] ce;
            logic [pesr_pkg::COORD_W+1:0] qe;
            logic [pesr_pkg::COORD_W+1:0] r;
            ce = {{2{cur_reg[i][pesr_pkg::COORD_W-1]}}, cur_reg[i]};
            qe = {1'b0, quo[i]};
            r  = neg_reg[i] ? (ce - qe) : (ce + qe);
            point[i] = d_zero_reg ? cur_reg[i] : r[pesr_pkg::COORD_W-1:0];
        end
    end

    pesr_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .rad     (sumsq_reg),
        .root    (d),
        .done    (sqrt_done)
    );

    // Three division lanes share the segment length as divisor.
    for (genvar g = 0; g < pesr_pkg::NAXES; g++) begin : g_div
        pesr_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (cmd.div_start),
            .num     ({1'b0, prod_reg[g]} + pesr_pkg::NUM_W'(d >> 1)),
            .den     (d),
            .quo     (quo[g]),
            .done    (div_done[g])
        );
    end

    // Control registers: spacing, pending flag and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg    <= pesr_pkg::SPACE_RST;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                spacing_reg <= cfg_data;
            end
            if (cmd.load_vtx) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.place_loop) begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Path state: position and leftover distance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            left_reg <= '0;
        end else begin
            if (cmd.load_start) begin
                cur_reg  <= vtx_in;
                left_reg <= '0;
            end else if (cmd.dec_end) begin
                cur_reg  <= vtx_reg;
                left_reg <= s_reg[pesr_pkg::SPACE_W-1:0];
            end else if (cmd.dec_ovf) begin
                cur_reg  <= vtx_reg;
                left_reg <= '0;
            end else if (cmd.place_loop) begin
                cur_reg  <= point;
                left_reg <= '0;
            end else if (cmd.place_end) begin
                cur_reg  <= vtx_reg;
                left_reg <= pesr_pkg::SPACE_W'(s_reg - pesr_pkg::SUM_W'(sp));
            end
        end
    end

    // Working registers of one segment pass.
    always_ff @(posedge aclk) begin
        if (cmd.load_vtx) begin
            vtx_reg <= vtx_in;
        end
        if (cmd.delta) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (cmd.sq_acc) begin
            sumsq_reg <= cmd.sq_first ? sq : (sumsq_reg + sq);
        end
        if (cmd.sum) begin
            s_reg      <= pesr_pkg::SUM_W'(d) + pesr_pkg::SUM_W'(left_reg);
            need_reg   <= (left_reg < sp) ? (sp - left_reg) : '0;
            d_zero_reg <= (d == '0);
        end
        if (cmd.mulq) begin
            for (int i = 0; i < pesr_pkg::NAXES; i++) begin
                prod_reg[i] <= mag_reg[i] * need_reg;
            end
        end
        if (cmd.place_loop) begin
            pend_reg <= point;
        end
        if (cmd.out_load) begin
            out_reg  <= (cmd.out_src == pesr_pkg::OUT_PEND) ? pend_reg : point;
            last_reg <= cmd.out_last;
            ovf_reg  <= cmd.out_ovf;
        end
    end

    always_comb begin
        status.out_free   = !out_valid_reg || m_tready;
        status.pend_valid = pend_valid_reg;
        status.s_le_sp    = (s_reg <= pesr_pkg::SUM_W'(sp));
        status.s_le_2sp   = (s_reg <= pesr_pkg::SUM_W'({sp, 1'b0}));
        status.d_zero     = d_zero_reg;
        status.sqrt_done  = sqrt_done;
        status.div_done   = div_done[0];
    end

    assign m_tvalid = out_valid_reg;
    assign pt_out   = out_reg;
    assign last_out = last_reg;
    assign ovf_out  = ovf_reg;

endmodule

### rtl/core/pesr_ctrl.sv
module pesr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              path_start,
    input  pesr_pkg::status_t status,
    output pesr_pkg::cmd_t    cmd
);

    pesr_pkg::state_t            state_reg, state_next;
    logic                        have_start_reg, have_start_next;
    logic [pesr_pkg::NPT_W-1:0]  npt_reg, npt_next;
    logic [1:0]                  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pesr_pkg::ST_IDLE;
            have_start_reg <= 1'b0;
            npt_reg        <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            have_start_reg <= have_start_next;
            npt_reg        <= npt_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Sequencing of one vertex: length, decision, interpolation, emission.
    always_comb begin
        state_next      = state_reg;
        have_start_next = have_start_reg;
        npt_next        = npt_reg;
        cnt_next        = cnt_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.out_src     = pesr_pkg::OUT_PEND;
        cmd.sq_sel      = cnt_reg;

        unique case (state_reg)
            pesr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_vtx = 1'b1;
                    npt_next     = '0;
                    if (path_start || !have_start_reg) begin
                        cmd.load_start  = 1'b1;
                        have_start_next = 1'b1;
                    end else begin
                        state_next = pesr_pkg::ST_DELTA;
                    end
                end
            end
            pesr_pkg::ST_DELTA: begin
                cmd.delta  = 1'b1;
                cnt_next   = '0;
                state_next = pesr_pkg::ST_SQR;
            end
            pesr_pkg::ST_SQR: begin
                cmd.sq_acc   = 1'b1;
                cmd.sq_first = (cnt_reg == 2'd0);
                if (cnt_reg == 2'(pesr_pkg::NAXES - 1)) begin
                    state_next = pesr_pkg::ST_SQ_GO;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pesr_pkg::ST_SQ_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = pesr_pkg::ST_SQ_WAIT;
            end
            pesr_pkg::ST_SQ_WAIT: begin
                if (status.sqrt_done) begin
                    state_next = pesr_pkg::ST_SUM;
                end
            end
            pesr_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = pesr_pkg::ST_DECIDE;
            end
            pesr_pkg::ST_DECIDE: begin
                if (status.s_le_sp) begin
                    // Vertex reached within the spacing: the held point is final.
                    if (!status.pend_valid) begin
                        cmd.dec_end = 1'b1;
                        state_next  = pesr_pkg::ST_IDLE;
                    end else if (status.out_free) begin
                        cmd.dec_end  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        state_next   = pesr_pkg::ST_IDLE;
                    end
                end else if (npt_reg >= pesr_pkg::NPT_W'(pesr_pkg::MAX_PER_VERTEX)) begin
                    // Limit reached: close the run with the overflow flag.
                    if (status.out_free) begin
                        cmd.dec_ovf  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        cmd.out_ovf  = 1'b1;
                        state_next   = pesr_pkg::ST_IDLE;
                    end
                end else if (!status.pend_valid || status.out_free) begin
                    cmd.out_load = status.pend_valid;
                    state_next   = status.d_zero ? pesr_pkg::ST_PLACE : pesr_pkg::ST_MULQ;
                end
            end
            pesr_pkg::ST_MULQ: begin
                cmd.mulq   = 1'b1;
                state_next = pesr_pkg::ST_DIV_GO;
            end
            pesr_pkg::ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = pesr_pkg::ST_DIV_WAIT;
            end
            pesr_pkg::ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = pesr_pkg::ST_PLACE;
                end
            end
            pesr_pkg::ST_PLACE: begin
                if (!status.s_le_2sp) begin
                    // More than one spacing left: hold the point and measure again.
                    cmd.place_loop = 1'b1;
                    npt_next       = npt_reg + 1'b1;
                    state_next     = pesr_pkg::ST_DELTA;
                end else if (status.out_free) begin
                    cmd.place_end  = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = pesr_pkg::OUT_POINT;
                    cmd.out_last   = 1'b1;
                    npt_next       = npt_reg + 1'b1;
                    state_next     = pesr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pesr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/polyline_equal_spacing_resampler_core.sv
// A path-start vertex is taken and emits nothing; the core stays ready. A vertex that places
// a single point offers it after the square-root wait, division wait and control states.
// A new vertex is taken only in idle, once the last one is done. Each point placed adds a
// length measurement and a division, except the one that ends the vertex, which adds only
// the division, plus any output stalls.
// Reset: synchronous, active low; clears position, leftover, spacing (to 256) and handshakes.
module polyline_equal_spacing_resampler_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write: spacing
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    // Vertex requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
    input  logic        s_tuser,   // path_start
    // Resampled points
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // overflow
);

    pesr_pkg::cmd_t    cmd;
    pesr_pkg::status_t status;
    logic [pesr_pkg::NAXES-1:0][pesr_pkg::COORD_W-1:0] pt_out;

    assign cfg_ready = 1'b1;
    assign m_tdata   = pt_out;

    pesr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .path_start (s_tuser),
        .status     (status),
        .cmd        (cmd)
    );

    pesr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .vtx_in   (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .pt_out   (pt_out),
        .last_out (m_tlast),
        .ovf_out  (m_tuser)
    );

endmodule

### rtl/core/pesr_checker.sv
module pesr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // No point is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("point offered right after reset");

    // Overflow is only flagged on the final point of a run.
    a_ovf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("overflow on a point that is not last");

    // A path-start vertex emits nothing and leaves the core ready.
    a_start_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> s_tready)
        else $error("core busy after a path-start vertex");

    // A stalled point holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("stalled point changed");

endmodule

bind polyline_equal_spacing_resampler_core pesr_checker u_pesr_checker (.*);

### test/polyline_equal_spacing_resampler_core_tb.sv
`timescale 1ns / 1ps

module polyline_equal_spacing_resampler_core_tb;

    localparam int  QUIET_LIMIT = 20000;
    localparam int  SETTLE_CYC  = 200;
    localparam int  MAXPTS      = pesr_pkg::MAX_PER_VERTEX;
    localparam longint SPACING_MAX = 64'h7FFF_FFFF;

    typedef struct {
        bit [pesr_pkg::COORD_W-1:0] px;
        bit [pesr_pkg::COORD_W-1:0] py;
        bit [pesr_pkg::COORD_W-1:0] pz;
        bit               last_pt;
        bit               ovf;
    } point_t;

    // Predicts the resampled points and checks them in arrival order.
    class point_scoreboard;
        point_t        expected_pts[$];
        longint        cur_x, cur_y, cur_z;
        longint unsigned leftover;
        longint unsigned spacing_q;
        bit            path_open;
        int            mismatches;
        int            points_seen;
        int            overflow_seen;

        function new();
            cur_x = 0; cur_y = 0; cur_z = 0;
            leftover = 0; spacing_q = 256; path_open = 0;
            mismatches = 0; points_seen = 0; overflow_seen = 0;
        endfunction

        function longint unsigned seg_len(longint dx, longint dy, longint dz);
            bit [67:0] ax;
            bit [67:0] ay;
            bit [67:0] az;
            bit [67:0] acc;
            bit [67:0] trial;
            bit [33:0] root;
            ax = 68'((dx < 0) ? -dx : dx);
            ay = 68'((dy < 0) ? -dy : dy);
            az = 68'((dz < 0) ? -dz : dz);
            acc = ax * ax + ay * ay + az * az;
            root = '0;
            for (int b = 33; b >= 0; b--) begin
                trial = 68'(root | (34'd1 << b));
                if (trial * trial <= acc) begin
                    root = trial[33:0];
                end
            end
            return longint'(root);
        endfunction

        // Rounds to nearest, ties away from zero, on the magnitude.
        function longint step_axis(longint from, longint delta, longint unsigned need,
                                   longint unsigned d);
            bit [79:0] num;
            longint    q;
            longint    amag;
            amag = (delta < 0) ? -delta : delta;
            num = 80'(amag) * 80'(need) + 80'(d / 2);
            q = longint'(num / 80'(d));
            return (delta < 0) ? from - q : from + q;
        endfunction

        // Notes an accepted vertex request and queues the points it causes.
        function void note_vertex(bit [pesr_pkg::COORD_W-1:0] vx_b,
                                  bit [pesr_pkg::COORD_W-1:0] vy_b,
                                  bit [pesr_pkg::COORD_W-1:0] vz_b, bit start);
            longint vx, vy, vz, dx, dy, dz, px, py, pz;
            longint unsigned d, s, sp, need;
            point_t run_pts[$];
            point_t pt;
            vx = longint'($signed(vx_b));
            vy = longint'($signed(vy_b));
            vz = longint'($signed(vz_b));
            if (start || !path_open) begin
                cur_x = vx; cur_y = vy; cur_z = vz;
                leftover = 0;
                path_open = 1;
                return;
            end
            sp = (spacing_q == 0) ? 1 : spacing_q;
            forever begin
                dx = vx - cur_x; dy = vy - cur_y; dz = vz - cur_z;
                d = seg_len(dx, dy, dz);
                s = d + leftover;
                if (s <= sp) begin
                    leftover = s;
                    cur_x = vx; cur_y = vy; cur_z = vz;
                    break;
                end
                if (run_pts.size() >= MAXPTS) begin
                    run_pts[run_pts.size()-1].ovf = 1;
                    cur_x = vx; cur_y = vy; cur_z = vz;
                    leftover = 0;
                    break;
                end
                need = (leftover < sp) ? sp - leftover : 0;
                px = cur_x; py = cur_y; pz = cur_z;
                if (d != 0) begin
                    px = step_axis(cur_x, dx, need, d);
                    py = step_axis(cur_y, dy, need, d);
                    pz = step_axis(cur_z, dz, need, d);
                end
                pt.px = px[31:0]; pt.py = py[31:0]; pt.pz = pz[31:0];
                pt.last_pt = 0; pt.ovf = 0;
                run_pts.push_back(pt);
                if (s > 2 * sp) begin
                    cur_x = px; cur_y = py; cur_z = pz;
                    leftover = 0;
                end else begin
                    leftover = s - sp;
                    cur_x = vx; cur_y = vy; cur_z = vz;
                    break;
                end
            end
            if (run_pts.size() > 0) begin
                run_pts[run_pts.size()-1].last_pt = 1;
            end
            foreach (run_pts[i]) expected_pts.push_back(run_pts[i]);
        endfunction

        function void check_point(bit [95:0] data, bit tlast, bit tuser);
            point_t e;
            points_seen++;
            if (tuser) overflow_seen++;
            if (expected_pts.size() == 0) begin
                $error("unexpected point x=%0h y=%0h z=%0h", data[31:0], data[63:32],
                       data[95:64]);
                mismatches++;
                return;
            end
            e = expected_pts.pop_front();
            if (data[31:0] != e.px) begin
                $error("point_x expected %0h actual %0h", e.px, data[31:0]);
                mismatches++;
            end
            if (data[63:32] != e.py) begin
                $error("point_y expected %0h actual %0h", e.py, data[63:32]);
                mismatches++;
            end
            if (data[95:64] != e.pz) begin
                $error("point_z expected %0h actual %0h", e.pz, data[95:64]);
                mismatches++;
            end
            if (tlast != e.last_pt) begin
                $error("last_of_run expected %0b actual %0b", e.last_pt, tlast);
                mismatches++;
            end
            if (tuser != e.ovf) begin
                $error("overflow expected %0b actual %0b", e.ovf, tuser);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_pts.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    point_scoreboard sb;
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      rx_hold;
    int      quiet_cycles;
    int      vertices_sent;
    longint  last_x, last_y, last_z;

    polyline_equal_spacing_resampler_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver readiness: random idling plus an optional long hold-off.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result monitor and watchdog on idle handshakes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_point(m_tdata, m_tlast, m_tuser);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("polyline_equal_spacing_resampler_core_tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Sends one vertex request and records it once accepted.
    task automatic send_vertex(longint x, longint y, longint z, bit start);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z[31:0], y[31:0], x[31:0]};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        sb.note_vertex(x[31:0], y[31:0], z[31:0], start);
        last_x = longint'($signed(x[31:0]));
        last_y = longint'($signed(y[31:0]));
        last_z = longint'($signed(z[31:0]));
        vertices_sent++;
    endtask

    // Waits for every expected point, then for a vertex still in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_spacing(longint value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value[30:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.spacing_q = longint'(value[30:0]);
    endtask

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // Mostly path continuations near the last vertex, some restarts and wild jumps.
    task automatic random_vertices(int count);
        int     pick;
        longint reach;
        for (int i = 0; i < count; i++) begin
            pick  = $urandom_range(99);
            reach = 3 * sb.spacing_q + 8;
            if (pick < 4) begin
                send_vertex(longint'($signed($urandom)), longint'($signed($urandom)),
                            longint'($signed($urandom)), 1'($urandom_range(1)));
            end else if (pick < 12) begin
                send_vertex(longint'($signed($urandom)) >>> 4,
                            longint'($signed($urandom)) >>> 4,
                            longint'($signed($urandom)) >>> 4, 1'b1);
            end else begin
                send_vertex(clamp32(last_x + longint'($urandom_range(2 * reach)) - reach),
                            clamp32(last_y + longint'($urandom_range(2 * reach)) - reach),
                            clamp32(last_z + longint'($urandom_range(reach)) - reach / 2),
                            1'b0);
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        tx_idle_pct = 15;
        rx_idle_pct = 80;
        rx_hold = 0;
        quiet_cycles = 0;
        vertices_sent = 0;
        last_x = 0; last_y = 0; last_z = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a first vertex without a path start opens the path.
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(700, 0, 0, 1'b0);
        send_vertex(700, 300, -200, 1'b0);
        send_vertex(700, 300, -200, 1'b0);
        send_vertex(700, 300, -150, 1'b0);
        send_vertex(700, 330, -150, 1'b0);

        // Spacing lowered below the leftover, then a zero-length segment.
        write_spacing(50);
        send_vertex(700, 330, -150, 1'b0);
        send_vertex(640, 330, -150, 1'b0);

        // Smallest spacing: a long segment hits the per-vertex limit.
        write_spacing(1);
        send_vertex(0, 0, 0, 1'b1);
        send_vertex(1000, -1000, 500, 1'b0);
        send_vertex(1001, -1000, 500, 1'b0);

        // Largest spacing across the full coordinate range.
        write_spacing(SPACING_MAX);
        send_vertex(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 1'b1);
        send_vertex(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 1'b0);
        send_vertex(-64'sh8000_0000, 64'sh7FFF_FFFF, -64'sh8000_0000, 1'b0);
        send_vertex(64'sh7FFF_FFFF, -64'sh8000_0000, 0, 1'b1);
        send_vertex(-1, -1, -1, 1'b0);

        // Random phase one: slow receiver, with a long hold-off while requests pile up.
        write_spacing(256);
        rx_hold = 400;
        random_vertices(137);

        // Random phase two: slow sender, random spacing.
        write_spacing($urandom_range(40, 3000));
        tx_idle_pct = 80;
        rx_idle_pct = 15;
        random_vertices(137);

        // Random phase three: no idling on either side.
        write_spacing($urandom_range(40, 3000));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_vertices(137);

        drain();
        $display("covered %0d vertices, %0d points (%0d with overflow), spacing 1 to 2^31-1",
                 vertices_sent, sb.points_seen, sb.overflow_seen);
        $display("idling on each side, a long receiver hold-off and mid-path spacing changes");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("polyline_equal_spacing_resampler_core_tb: PASS");
        end else begin
            $display("polyline_equal_spacing_resampler_core_tb: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/pesr_pkg.sv
rtl/core/pesr_sqrt.sv
rtl/core/pesr_div.sv
rtl/core/pesr_dp.sv
rtl/core/pesr_ctrl.sv
rtl/core/polyline_equal_spacing_resampler_core.sv
rtl/core/pesr_checker.sv
test/polyline_equal_spacing_resampler_core_tb.sv
